@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the xmodem block receiver.
// No dependencies; the using module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define XBR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define XBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xbr_pkg.sv @@
// Package for the xmodem block receiver: widths, codes, types, defaults.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package xbr_pkg;

  // Fixed field widths
  localparam int REQ_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 24;
  localparam int RETRY_W  = 8;
  localparam int STOFF_W  = 24;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // Parameter defaults
  localparam int DEF_BLOCK_BYTES = 128;
  localparam int DEF_OFFSET_BITS = 24;

  // Configuration reset values
  localparam logic [TICK_W-1:0]  RST_START_WAIT = 24'h080000;
  localparam logic [TICK_W-1:0]  RST_BYTE_WAIT  = 24'h020000;
  localparam logic [RETRY_W-1:0] RST_RETRIES    = 8'd66;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_WAIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIES    = 2'd2;

  // Link characters
  localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] CH_CAN = 8'h18;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RUN      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSENDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABORTED  = 2'd3;

  // Receiver phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_WAIT_START = 10'b00_0000_0010,
    PH_BLK        = 10'b00_0000_0100,
    PH_CMP        = 10'b00_0000_1000,
    PH_DATA       = 10'b00_0001_0000,
    PH_SUM        = 10'b00_0010_0000,
    PH_NEXT       = 10'b00_0100_0000,
    PH_DONE       = 10'b00_1000_0000,
    PH_NOSENDER   = 10'b01_0000_0000,
    PH_ABORTED    = 10'b10_0000_0000
  } phase_t;

  // One input word
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    logic                send_valid;
    logic [BYTE_W-1:0]   send_byte;
    logic                store_valid;
    logic [STOFF_W-1:0]  store_offset;
    logic [BYTE_W-1:0]   store_byte;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Status reported for a phase
  function automatic logic [STATUS_W-1:0] status_of(input phase_t ph);
    logic [STATUS_W-1:0] st;
    case (ph)
      PH_DONE:     st = ST_COMPLETE;
      PH_NOSENDER: st = ST_NOSENDER;
      PH_ABORTED:  st = ST_ABORTED;
      default:     st = ST_RUN;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

@@ rtl/xbr_if.sv @@
// Channel interfaces of the xmodem block receiver: input, result, config.
// Depends on xbr_pkg.
`default_nettype none

interface xbr_in_if;
  import xbr_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface xbr_out_if;
  import xbr_pkg::*;
  logic                valid;
  logic                ready;
  logic                send_valid;
  logic [BYTE_W-1:0]   send_byte;
  logic                store_valid;
  logic [STOFF_W-1:0]  store_offset;
  logic [BYTE_W-1:0]   store_byte;
  logic [STATUS_W-1:0] status;
  modport source (output valid, send_valid, send_byte, store_valid, store_offset,
                  store_byte, status, input ready);
  modport sink   (input valid, send_valid, send_byte, store_valid, store_offset,
                  store_byte, status, output ready);
endinterface

interface xbr_cfg_if;
  import xbr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/xmodem_block_receiver.sv @@
// Top level of the xmodem block receiver (checksum mode).
// Depends on xbr_pkg, xbr_if, xbr_in_stage, xbr_core, xbr_out_stage, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// XMODEM receiver, checksum mode. Each input word is a received byte, a timer
// tick or a start request, and each gives exactly one result word carrying an
// optional control byte to send (NAK, ACK or CAN), an optional payload byte with
// its running store offset, and the transfer status after that word. One word is
// taken every clock cycle while the result channel keeps up, as xbr_core updates
// its state as each word moves on. A word passes the input register and then
// the result register before its result is on the result channel. A stalled result
// channel fills both registers before the input side stalls.
// Configuration writes are taken at any time but are meant for an idle block;
// there is no clearing pass after reset.
module xmodem_block_receiver #(
  parameter int BLOCK_BYTES = xbr_pkg::DEF_BLOCK_BYTES,
  parameter int OFFSET_BITS = xbr_pkg::DEF_OFFSET_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  xbr_in_if.sink     in_if,
  xbr_out_if.source  out_if,
  xbr_cfg_if.sink    cfg_if
);
  import xbr_pkg::*;

  logic    held_valid;
  item_t   held_item;
  logic    can_load;
  logic    advance;
  result_t core_res;

  // Word moves from the input register into the result register
  assign advance = held_valid && can_load;

  xbr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  xbr_core #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .fire   (advance),
    .item   (held_item),
    .result (core_res)
  );

  xbr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .result   (core_res),
    .can_load (can_load),
    .out_if   (out_if)
  );

  // Checks
  `XBR_ASSERT_SAME(a_no_send_and_store, out_if.valid, !(out_if.send_valid && out_if.store_valid), "control byte and payload byte in one word")
  `XBR_ASSERT_SAME(a_store_while_running, out_if.valid && out_if.store_valid, out_if.status == ST_RUN, "payload byte with a final status")
  `XBR_ASSERT_SAME(a_empty_input_ready, !held_valid, in_if.ready, "input side stalled with an empty input register")
  `XBR_ASSERT_NEXT(a_advance_loads_out, advance, out_if.valid, "result register not loaded after a word moved on")

endmodule

`default_nettype wire

@@ rtl/xbr_in_stage.sv @@
// Input register of the xmodem block receiver: holds one word for the core.
// Depends on xbr_pkg and xbr_in_if.
`default_nettype none

module xbr_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  xbr_in_if.sink          in_if,
  input  logic            advance,   // core consumes the held word this cycle
  output logic            held_valid,
  output xbr_pkg::item_t  held_item
);
  import xbr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  // Room when empty or when the held word moves on this cycle
  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.req_type <= in_if.req_type;
      item_r.rx_byte  <= in_if.rx_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

`default_nettype wire

@@ rtl/xbr_core.sv @@
// Receiver core: config registers, protocol state and single-pass result logic.
// Depends on xbr_pkg and xbr_cfg_if.
`default_nettype none

module xbr_core #(
  parameter int BLOCK_BYTES = xbr_pkg::DEF_BLOCK_BYTES,
  parameter int OFFSET_BITS = xbr_pkg::DEF_OFFSET_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  xbr_cfg_if.sink          cfg_if,
  input  logic             fire,     // process the held word now
  input  xbr_pkg::item_t   item,
  output xbr_pkg::result_t result
);
  import xbr_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BYTES - 1);

  // Configuration registers
  logic [TICK_W-1:0]  start_wait_r;
  logic [TICK_W-1:0]  byte_wait_r;
  logic [RETRY_W-1:0] retries_cfg_r;

  // Protocol state
  phase_t                 phase_r, phase_nxt;
  logic [BYTE_W-1:0]      block_num_r, block_num_nxt;
  logic [CNT_W-1:0]       byte_cnt_r, byte_cnt_nxt;
  logic [BYTE_W-1:0]      sum_r, sum_nxt;
  logic [TICK_W-1:0]      timer_r, timer_nxt;
  logic [RETRY_W-1:0]     retries_r, retries_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  logic              active;
  logic [TICK_W-1:0] timer_dec;
  result_t           res;

  assign cfg_if.ready = 1'b1;

  // Config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_wait_r  <= RST_START_WAIT;
      byte_wait_r   <= RST_BYTE_WAIT;
      retries_cfg_r <= RST_RETRIES;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        CFG_START_WAIT: start_wait_r  <= cfg_if.wdata;
        CFG_BYTE_WAIT:  byte_wait_r   <= cfg_if.wdata;
        CFG_RETRIES:    retries_cfg_r <= cfg_if.wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign active    = phase_r inside {PH_WAIT_START, PH_BLK, PH_CMP, PH_DATA, PH_SUM,
                                     PH_NEXT};
  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : '0;

  // Next state and result for the held word
  always_comb begin
    phase_nxt     = phase_r;
    block_num_nxt = block_num_r;
    byte_cnt_nxt  = byte_cnt_r;
    sum_nxt       = sum_r;
    timer_nxt     = timer_r;
    retries_nxt   = retries_r;
    offset_nxt    = offset_r;
    res           = '0;

    case (item.req_type)
      REQ_START: begin
        phase_nxt      = PH_WAIT_START;
        block_num_nxt  = 8'd1;
        byte_cnt_nxt   = '0;
        sum_nxt        = '0;
        offset_nxt     = '0;
        retries_nxt    = retries_cfg_r;
        timer_nxt      = start_wait_r;
        res.send_valid = 1'b1;
        res.send_byte  = CH_NAK;
      end
      REQ_TICK: begin
        if (active) begin
          timer_nxt = timer_dec;
          if (timer_dec == '0) begin
            res.send_valid = 1'b1;
            if (phase_r == PH_WAIT_START) begin
              if (retries_r != '0) begin
                // Start wait expired: resend NAK
                retries_nxt   = retries_r - 1'b1;
                timer_nxt     = start_wait_r;
                res.send_byte = CH_NAK;
              end else begin
                res.send_byte = CH_CAN;
                phase_nxt     = PH_NOSENDER;
              end
            end else begin
              res.send_byte = CH_CAN;
              phase_nxt     = PH_ABORTED;
            end
          end
        end
      end
      REQ_BYTE: begin
        if (active) begin
          timer_nxt = byte_wait_r;
          case (phase_r)
            PH_WAIT_START: begin
              if (item.rx_byte == CH_SOH) begin
                phase_nxt = PH_BLK;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = CH_CAN;
                phase_nxt      = PH_ABORTED;
              end
            end
            PH_NEXT: begin
              if (item.rx_byte == CH_SOH) begin
                phase_nxt = PH_BLK;
              end else if (item.rx_byte == CH_EOT) begin
                res.send_valid = 1'b1;
                res.send_byte  = CH_ACK;
                phase_nxt      = PH_DONE;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = CH_CAN;
                phase_nxt      = PH_ABORTED;
              end
            end
            PH_BLK: begin
              if (item.rx_byte == block_num_r) begin
                phase_nxt = PH_CMP;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = CH_CAN;
                phase_nxt      = PH_ABORTED;
              end
            end
            PH_CMP: begin
              if (item.rx_byte == ~block_num_r) begin
                phase_nxt    = PH_DATA;
                byte_cnt_nxt = '0;
                sum_nxt      = '0;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = CH_CAN;
                phase_nxt      = PH_ABORTED;
              end
            end
            PH_DATA: begin
              // Payload byte: store at running offset, fold into sum
              res.store_valid  = 1'b1;
              res.store_offset = STOFF_W'(offset_r);
              res.store_byte   = item.rx_byte;
              offset_nxt       = offset_r + 1'b1;
              sum_nxt          = sum_r + item.rx_byte;
              if (byte_cnt_r == CNT_LAST) begin
                byte_cnt_nxt = '0;
                phase_nxt    = PH_SUM;
              end else begin
                byte_cnt_nxt = byte_cnt_r + 1'b1;
              end
            end
            PH_SUM: begin
              res.send_valid = 1'b1;
              if (item.rx_byte == sum_r) begin
                res.send_byte = CH_ACK;
                block_num_nxt = block_num_r + 1'b1;
                phase_nxt     = PH_NEXT;
              end else begin
                res.send_byte = CH_CAN;
                phase_nxt     = PH_ABORTED;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    res.status = status_of(phase_nxt);
  end

  // State update, one word per cycle while fire is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      block_num_r <= 8'd1;
      byte_cnt_r  <= '0;
      sum_r       <= '0;
      timer_r     <= '0;
      retries_r   <= '0;
      offset_r    <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      block_num_r <= block_num_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      sum_r       <= sum_nxt;
      timer_r     <= timer_nxt;
      retries_r   <= retries_nxt;
      offset_r    <= offset_nxt;
    end
  end

  assign result = res;

endmodule

`default_nettype wire

@@ rtl/xbr_out_stage.sv @@
// Result register of the xmodem block receiver, drives the result channel.
// Depends on xbr_pkg and xbr_out_if.
`default_nettype none

module xbr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  xbr_pkg::result_t result,
  output logic             can_load,   // empty, or the held word leaves now
  xbr_out_if.source        out_if
);
  import xbr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.send_valid   = res_r.send_valid;
  assign out_if.send_byte    = res_r.send_byte;
  assign out_if.store_valid  = res_r.store_valid;
  assign out_if.store_offset = res_r.store_offset;
  assign out_if.store_byte   = res_r.store_byte;
  assign out_if.status       = res_r.status;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the xmodem block receiver: directed table, then random transfers.
// Depends on xbr_pkg, the channel interfaces in xbr_if and the xmodem_block_receiver RTL.
module tb_top;
  import xbr_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 11;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int BLOCK_LEN = 128;
  localparam int ITEM_TARGET = 1400;
  localparam int WORDS_PER_SETTING = 220;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  // One row of the directed table; res only counts when typed is set
  typedef struct {
    item_t   word;
    bit      typed;
    result_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  xbr_in_if  in_ch ();
  xbr_out_if out_ch ();
  xbr_cfg_if cfg_ch ();

  xmodem_block_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver state as the testbench sees it
  phase_t       rx_phase;
  logic [7:0]   rx_block;
  logic [7:0]   rx_count;
  logic [7:0]   rx_sum;
  logic [23:0]  rx_timer;
  logic [7:0]   rx_retries;
  logic [23:0]  rx_offset;
  logic [23:0]  set_start_wait;
  logic [23:0]  set_byte_wait;
  logic [7:0]   set_retries;

  result_t      pending_results[$];
  stim_row_t    directed_rows[$];
  item_t        session_q[$];
  int           error_count = 0;
  int           words_sent;
  bit           in_steady;
  bit           out_steady;
  int           idle_cycles = 0;

  // Next receiver state and the result word for one accepted input word
  function automatic result_t receiver_step(input logic [REQ_W-1:0] req,
                                            input logic [7:0] b);
    result_t r;
    bit      active;
    bit      bad;
    r = '0;
    bad = 1'b0;
    active = (rx_phase == PH_WAIT_START) || (rx_phase == PH_BLK) || (rx_phase == PH_CMP) ||
             (rx_phase == PH_DATA) || (rx_phase == PH_SUM) || (rx_phase == PH_NEXT);
    if (req == REQ_START) begin
      rx_phase = PH_WAIT_START;
      rx_block = 8'd1;
      rx_count = 8'd0;
      rx_sum = 8'd0;
      rx_offset = 24'd0;
      rx_retries = set_retries;
      rx_timer = set_start_wait;
      r.send_valid = 1'b1;
      r.send_byte = CH_NAK;
    end else if (req == REQ_TICK && active) begin
      if (rx_timer != 24'd0) rx_timer = rx_timer - 1'b1;
      if (rx_timer == 24'd0) begin
        r.send_valid = 1'b1;
        if (rx_phase == PH_WAIT_START) begin
          // start wait: resend NAK while retries remain, then give up
          if (rx_retries != 8'd0) begin
            rx_retries = rx_retries - 1'b1;
            rx_timer = set_start_wait;
            r.send_byte = CH_NAK;
          end else begin
            r.send_byte = CH_CAN;
            rx_phase = PH_NOSENDER;
          end
        end else begin
          r.send_byte = CH_CAN;
          rx_phase = PH_ABORTED;
        end
      end
    end else if (req == REQ_BYTE && active) begin
      rx_timer = set_byte_wait;
      case (rx_phase)
        PH_WAIT_START: begin
          if (b == CH_SOH) rx_phase = PH_BLK;
          else bad = 1'b1;
        end
        PH_NEXT: begin
          if (b == CH_SOH) begin
            rx_phase = PH_BLK;
          end else if (b == CH_EOT) begin
            r.send_valid = 1'b1;
            r.send_byte = CH_ACK;
            rx_phase = PH_DONE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_BLK: begin
          if (b == rx_block) rx_phase = PH_CMP;
          else bad = 1'b1;
        end
        PH_CMP: begin
          if (b == ~rx_block) begin
            rx_phase = PH_DATA;
            rx_count = 8'd0;
            rx_sum = 8'd0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA: begin
          r.store_valid = 1'b1;
          r.store_offset = rx_offset;
          r.store_byte = b;
          rx_offset = rx_offset + 1'b1;
          rx_sum = rx_sum + b;
          if (rx_count == BLOCK_LEN - 1) begin
            rx_count = 8'd0;
            rx_phase = PH_SUM;
          end else begin
            rx_count = rx_count + 1'b1;
          end
        end
        PH_SUM: begin
          if (b == rx_sum) begin
            r.send_valid = 1'b1;
            r.send_byte = CH_ACK;
            rx_block = rx_block + 1'b1;
            rx_phase = PH_NEXT;
          end else begin
            bad = 1'b1;
          end
        end
        default: ;
      endcase
      if (bad) begin
        r.send_valid = 1'b1;
        r.send_byte = CH_CAN;
        rx_phase = PH_ABORTED;
      end
    end
    case (rx_phase)
      PH_DONE:     r.status = ST_COMPLETE;
      PH_NOSENDER: r.status = ST_NOSENDER;
      PH_ABORTED:  r.status = ST_ABORTED;
      default:     r.status = ST_RUN;
    endcase
    return r;
  endfunction

  function automatic result_t outcome(input bit snd, input logic [7:0] ch, input bit sto,
                                      input logic [23:0] off, input logic [7:0] b,
                                      input logic [STATUS_W-1:0] st);
    result_t r;
    r.send_valid = snd;
    r.send_byte = ch;
    r.store_valid = sto;
    r.store_offset = off;
    r.store_byte = b;
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(input logic [REQ_W-1:0] req, input logic [7:0] b,
                                  input bit typed, input result_t res);
    stim_row_t row;
    row.word.req_type = req;
    row.word.rx_byte = b;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, actual %0h", name, expv, actv);
      error_count++;
    end
  endfunction

  // Offer one input word, wait for its handshake, then predict its result
  task automatic send_word(input item_t w, input bit typed, input result_t typed_res);
    int      gap;
    bit      taken;
    result_t pred;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= w.req_type;
    in_ch.rx_byte <= w.rx_byte;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    pred = receiver_step(w.req_type, w.rx_byte);
    pending_results.push_back(typed ? typed_res : pred);
    words_sent++;
  endtask

  // Configuration write; valid is left high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= value;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      CFG_START_WAIT: set_start_wait = value;
      CFG_BYTE_WAIT:  set_byte_wait = value;
      CFG_RETRIES:    set_retries = value[7:0];
      default: ;
    endcase
  endtask

  // Stop offering words and let every outstanding result come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] start_wait, input logic [23:0] byte_wait,
                                input logic [7:0] retries);
    drain_results();
    write_register(CFG_START_WAIT, start_wait);
    write_register(CFG_BYTE_WAIT, byte_wait);
    write_register(CFG_RETRIES, {16'd0, retries});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_word(input logic [REQ_W-1:0] req, input logic [7:0] b);
    item_t w;
    w.req_type = req;
    w.rx_byte = b;
    session_q.push_back(w);
  endfunction

  function automatic void add_ticks(input int n);
    repeat (n) add_word(REQ_TICK, 8'($urandom_range(0, 255)));
  endfunction

  // Transfer of one or two blocks ended by EOT; when broken, one byte is
  // corrupted or one inter-byte gap runs into the timeout
  function automatic void build_transfer(input bit broken);
    logic [7:0] frame[$];
    logic [7:0] blk;
    logic [7:0] sum;
    logic [7:0] b;
    int         nblk;
    int         fault_at;
    int         n;
    bit         stall_fault;
    longint     budget;
    blk = 8'd1;
    nblk = $urandom_range(1, 2);
    repeat (nblk) begin
      frame.push_back(CH_SOH);
      frame.push_back(blk);
      frame.push_back(~blk);
      sum = 8'd0;
      repeat (BLOCK_LEN) begin
        b = 8'($urandom_range(0, 255));
        frame.push_back(b);
        sum = sum + b;
      end
      frame.push_back(sum);
      blk = blk + 1'b1;
    end
    frame.push_back(CH_EOT);

    fault_at = -1;
    stall_fault = 1'b0;
    if (broken) begin
      fault_at = $urandom_range(0, frame.size() - 1);
      if (fault_at > 0 && set_byte_wait <= 64 && $urandom_range(0, 2) == 0)
        stall_fault = 1'b1;
      else
        frame[fault_at] = frame[fault_at] ^ 8'($urandom_range(1, 255));
    end

    add_word(REQ_START, 8'($urandom_range(0, 255)));
    // some ticks before the sender shows up, short of giving up
    budget = longint'(set_start_wait) * (longint'(set_retries) + 1);
    if ($urandom_range(0, 2) == 0) begin
      n = (budget - 1 > 30) ? 30 : int'(budget - 1);
      add_ticks($urandom_range(0, n));
    end
    foreach (frame[i]) begin
      if (i == fault_at && stall_fault) begin
        add_ticks(int'(set_byte_wait));
      end else if (i > 0 && set_byte_wait > 1 && $urandom_range(0, 7) == 0) begin
        n = (set_byte_wait - 1 > 3) ? 3 : int'(set_byte_wait - 1);
        add_ticks($urandom_range(1, n));
      end
      add_word(REQ_BYTE, frame[i]);
    end
  endfunction

  // Start request and a sender that never answers
  function automatic void build_no_sender();
    longint budget;
    budget = longint'(set_start_wait) * (longint'(set_retries) + 1);
    add_word(REQ_START, 8'($urandom_range(0, 255)));
    add_ticks((budget <= 600) ? int'(budget) : $urandom_range(1, 600));
    add_word(REQ_TICK, 8'($urandom_range(0, 255)));
    add_word(REQ_BYTE, CH_SOH);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12))
      add_word(REQ_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endfunction

  // Result side: random stalls, each word checked against the oldest expectation
  initial begin : result_sink
    result_t want;
    int      stall;
    bit      taken;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = (out_ch.valid === 1'b1);
        if (taken) begin
          if (pending_results.size() == 0) begin
            $error("result word with no expectation pending");
            error_count++;
          end else begin
            want = pending_results.pop_front();
            check_field("send_valid", want.send_valid, out_ch.send_valid);
            check_field("send_byte", want.send_byte, out_ch.send_byte);
            check_field("store_valid", want.store_valid, out_ch.store_valid);
            check_field("store_offset", want.store_offset, out_ch.store_offset);
            check_field("store_byte", want.store_byte, out_ch.store_byte);
            check_field("status", want.status, out_ch.status);
          end
        end
        @(posedge clk);
      end while (!taken);
    end
  end

  // Watchdog on cycles without any handshake
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int pick;
    int setting_no;
    int setting_start;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= CFG_START_WAIT;
    cfg_ch.wdata <= 24'd0;

    rx_phase = PH_IDLE;
    rx_block = 8'd1;
    rx_count = 8'd0;
    rx_sum = 8'd0;
    rx_timer = 24'd0;
    rx_retries = 8'd0;
    rx_offset = 24'd0;
    set_start_wait = RST_START_WAIT;
    set_byte_wait = RST_BYTE_WAIT;
    set_retries = RST_RETRIES;
    in_steady = 1'b0;
    out_steady = 1'b0;
    words_sent = 0;

    // Directed table, run with the reset settings
    //      request     byte    typed  snd  ch      sto  offset  data   status
    add_row(REQ_TICK,   8'h00,  1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   8'hFF,  1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_UNUSED, 8'hAA,  1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_START,  8'h55,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   8'h00,  1, outcome(1, CH_CAN, 0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_TICK,   8'hFF,  1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_BYTE,   CH_SOH, 1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_START,  8'h00,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   CH_SOH, 0, '0);
    add_row(REQ_BYTE,   8'h02,  1, outcome(1, CH_CAN, 0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_START,  8'hFF,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   CH_SOH, 0, '0);
    add_row(REQ_BYTE,   8'h01,  0, '0);
    add_row(REQ_BYTE,   8'h01,  1, outcome(1, CH_CAN, 0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_START,  8'h00,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   CH_SOH, 0, '0);
    add_row(REQ_BYTE,   8'h01,  0, '0);
    add_row(REQ_BYTE,   8'hFE,  0, '0);
    add_row(REQ_BYTE,   8'hFF,  1, outcome(0, 8'h00,  1, 24'd0, 8'hFF, ST_RUN));
    add_row(REQ_BYTE,   8'h00,  1, outcome(0, 8'h00,  1, 24'd1, 8'h00, ST_RUN));
    add_row(REQ_TICK,   8'h00,  1, outcome(0, 8'h00,  0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_START,  8'h00,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   CH_EOT, 1, outcome(1, CH_CAN, 0, 24'd0, 8'h00, ST_ABORTED));
    add_row(REQ_START,  8'h00,  1, outcome(1, CH_NAK, 0, 24'd0, 8'h00, ST_RUN));
    add_row(REQ_BYTE,   CH_SOH, 0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

    // Random transfers under several settings, the extremes first
    setting_no = 0;
    while (words_sent < ITEM_TARGET) begin
      case (setting_no)
        0: apply_settings(24'd1, 24'd1, 8'd0);
        1: apply_settings(24'hFFFFFF, 24'hFFFFFF, 8'hFF);
        2: apply_settings(24'd1, 24'd5, 8'hFF);
        default: apply_settings(24'($urandom_range(1, 12)), 24'($urandom_range(1, 12)),
                                8'($urandom_range(0, 6)));
      endcase
      setting_start = words_sent;
      while (words_sent - setting_start < WORDS_PER_SETTING) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) build_transfer(1'b0);
        else if (pick < 8) build_transfer(1'b1);
        else if (pick < 9) build_no_sender();
        else build_noise();
        in_steady = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
        foreach (session_q[i]) send_word(session_q[i], 1'b0, '0);
        session_q.delete();
      end
      setting_no++;
    end

    drain_results();
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/xbr_pkg.sv
rtl/xbr_if.sv
rtl/xbr_in_stage.sv
rtl/xbr_core.sv
rtl/xbr_out_stage.sv
rtl/xmodem_block_receiver.sv
sim/tb_top.sv
